### hdl/qs_pkg.sv
// Shared constants, types and state encoding for the quicksort engine.
package qs_pkg;

  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SET_W  = (DEPTH > 2) ? $clog2(DEPTH) : 1;

  typedef struct packed {
    logic                     v;
    logic signed [DATA_W-1:0] d;
  } link_t;

  typedef enum logic [1:0] {
    S_LOAD,
    S_SETTLE,
    S_DRAIN
  } state_t;

endpackage

### hdl/qs_cell.sv
// One sorting cell: keeps the smaller value, passes the larger one right, shifts left on drain.
module qs_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  qs_pkg::link_t left,
  input  qs_pkg::link_t right,
  output qs_pkg::link_t held,
  output qs_pkg::link_t pass
);
  import qs_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      held.v <= 1'b0;
      pass.v <= 1'b0;
    end else if (shift) begin
      held   <= right;
      pass.v <= 1'b0;
    end else if (left.v) begin
      if (!held.v) begin
        held   <= left;
        pass.v <= 1'b0;
      end else if ($signed(left.d) < $signed(held.d)) begin
        held.d <= left.d;
        pass   <= held;
      end else begin
        pass <= left;
      end
    end else begin
      pass.v <= 1'b0;
    end
  end

endmodule

### hdl/quicksort_engine.sv
// Top level of the batch sorter: load control, cell chain and result register.
//
//  channel | signals                              | role
//  req     | req_valid req_ready value last_in    | one value per request, last marked
//  res     | res_valid res_ready sorted_value     | ascending results, last_out and
//          |   last_out overflow                  |   overflow on each result
//
// Loading takes one request per cycle; each value enters cell 0 and ripples right.
// After the last request the chain settles long enough for the longest ripple path,
// then drains one result per cycle from cell 0 while the result side accepts.
// req_ready is low from the last request until the state returns to S_LOAD after the drain count reaches zero.
// Reset is synchronous; it empties the chain and clears count and flags.
module quicksort_engine (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  logic signed [qs_pkg::DATA_W-1:0] value,
  input  logic                             last_in,
  output logic                             res_valid,
  input  logic                             res_ready,
  output logic signed [qs_pkg::DATA_W-1:0] sorted_value,
  output logic                             last_out,
  output logic                             overflow
);
  import qs_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             ovf_seen;
  logic             ovf_next;
  logic             batch_ovf;
  logic [CNT_W-1:0] drain_left;
  logic [SET_W-1:0] settle_cnt;
  logic             accept;
  logic             has_room;
  logic             shift;
  logic             load_out;

  link_t held [DEPTH+1];
  link_t pass [DEPTH+1];

  assign accept     = req_valid && req_ready;
  assign has_room   = count < CNT_W'(DEPTH);
  assign count_next = has_room ? count + CNT_W'(1) : count;
  assign ovf_next   = ovf_seen || !has_room;

  // insertion into cell 0
  assign pass[0].v   = accept && has_room;
  assign pass[0].d   = value;
  assign held[DEPTH] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    qs_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .left  (pass[i]),
      .right (held[i+1]),
      .held  (held[i]),
      .pass  (pass[i+1])
    );
  end

  always_comb begin
    state_next = state;
    case (state)
      S_LOAD:   if (accept && last_in) state_next = S_SETTLE;
      S_SETTLE: if (settle_cnt == '0) state_next = S_DRAIN;
      S_DRAIN:  if (drain_left == '0) state_next = S_LOAD;
      default:  state_next = S_LOAD;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    load_out  = 1'b0;
    case (state)
      S_LOAD:   req_ready = 1'b1;
      S_SETTLE: load_out  = 1'b0;
      S_DRAIN:  load_out  = (drain_left != '0) && (!res_valid || res_ready);
      default:  req_ready = 1'b0;
    endcase
  end

  assign shift = load_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      count      <= '0;
      ovf_seen   <= 1'b0;
      batch_ovf  <= 1'b0;
      drain_left <= '0;
      settle_cnt <= '0;
      res_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (last_in) begin
          count      <= '0;
          ovf_seen   <= 1'b0;
          batch_ovf  <= ovf_next;
          drain_left <= count_next;
          settle_cnt <= SET_W'(DEPTH - 1);
        end else begin
          count    <= count_next;
          ovf_seen <= ovf_next;
        end
      end
      if (state == S_SETTLE) begin
        settle_cnt <= settle_cnt - SET_W'(1);
      end
      if (load_out) begin
        drain_left <= drain_left - CNT_W'(1);
        res_valid  <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      sorted_value <= held[0].d;
      last_out     <= (drain_left == CNT_W'(1));
      overflow     <= batch_ovf;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("element count beyond store size");

  a_drain_valid: assert property (@(posedge clk) disable iff (rst)
    load_out |-> held[0].v)
    else $error("drain read an empty cell");

  a_last_mark: assert property (@(posedge clk) disable iff (rst)
    (load_out && drain_left == CNT_W'(1)) |=> (res_valid && last_out))
    else $error("final result not marked");

  a_chain_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN && drain_left == '0) |-> !held[0].v)
    else $error("chain not empty after drain");

  a_no_spill: assert property (@(posedge clk) disable iff (rst)
    !pass[DEPTH].v)
    else $error("value pushed past the last cell");

endmodule
